// ----- rtl/assert_macros.svh -----
// Assertion macros used by the partition table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PNTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PNTM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define PNTM_ASSERT(lbl, prop, msg)
`define PNTM_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- rtl/pntm_pkg.sv -----
// Package: sizes, seed table and store write type for the partition number table.
package pntm_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned SEED_ENTRIES  = 128;
  localparam int unsigned IDX_W         = 12;
  localparam int unsigned VAL_W         = 64;
  localparam int unsigned ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = ADDR_W + 1;
  localparam int unsigned OFF_W         = ADDR_W + 2;
  localparam int unsigned ROM_W         = 7;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } pntm_wr_t;

  localparam logic [VAL_W-1:0] SEED_ROM [2**ROM_W] = '{
    64'd1, 64'd1, 64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd15, 64'd22, 64'd30,
    64'd42, 64'd56, 64'd77, 64'd101, 64'd135, 64'd176, 64'd231, 64'd297,
    64'd385, 64'd490, 64'd627, 64'd792, 64'd1002, 64'd1255, 64'd1575,
    64'd1958, 64'd2436, 64'd3010, 64'd3718, 64'd4565, 64'd5604, 64'd6842,
    64'd8349, 64'd10143, 64'd12310, 64'd14883, 64'd17977, 64'd21637,
    64'd26015, 64'd31185, 64'd37338, 64'd44583, 64'd53174, 64'd63261,
    64'd75175, 64'd89134, 64'd105558, 64'd124754, 64'd147273, 64'd173525,
    64'd204226, 64'd239943, 64'd281589, 64'd329931, 64'd386155, 64'd451276,
    64'd526823, 64'd614154, 64'd715220, 64'd831820, 64'd966467, 64'd1121505,
    64'd1300156, 64'd1505499, 64'd1741630, 64'd2012558, 64'd2323520,
    64'd2679689, 64'd3087735, 64'd3554345, 64'd4087968, 64'd4697205,
    64'd5392783, 64'd6185689, 64'd7089500, 64'd8118264, 64'd9289091,
    64'd10619863, 64'd12132164, 64'd13848650, 64'd15796476, 64'd18004327,
    64'd20506255, 64'd23338469, 64'd26543660, 64'd30167357, 64'd34262962,
    64'd38887673, 64'd44108109, 64'd49995925, 64'd56634173, 64'd64112359,
    64'd72533807, 64'd82010177, 64'd92669720, 64'd104651419, 64'd118114304,
    64'd133230930, 64'd150198136, 64'd169229875, 64'd190569292, 64'd214481126,
    64'd241265379, 64'd271248950, 64'd304801365, 64'd342325709, 64'd384276336,
    64'd431149389, 64'd483502844, 64'd541946240, 64'd607163746, 64'd679903203,
    64'd761002156, 64'd851376628, 64'd952050665, 64'd1064144451,
    64'd1188908248, 64'd1327710076, 64'd1482074143, 64'd1653668665,
    64'd1844349560, 64'd2056148051, 64'd2291320912, 64'd2552338241,
    64'd2841940500, 64'd3163127352, 64'd3519222692, 64'd3913864295
  };

endpackage

// ----- rtl/pntm_if.sv -----
// Channel interfaces: query items in, partition value items out.
interface pntm_in_if;
  import pntm_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  modport source (output valid, output index, input ready);
  modport sink (input valid, input index, output ready);
endinterface

interface pntm_out_if;
  import pntm_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic             out_of_range;
  modport source (output valid, output value, output out_of_range, input ready);
  modport sink (input valid, input value, input out_of_range, output ready);
endinterface

// ----- rtl/partition_number_table_mod_2_64_top.sv -----
// Top level: partition number p(n) mod 2^64 lookup with on-demand table extension.
//
// Channels: in_i carries a query item (index n), out_o one result item (value,
// out_of_range) per query. Both use valid/ready; an item moves when both are high.
// The block takes one query at a time; in_i.ready is high only while idle.
// An index already in the table is read in ST_LOOK and registered out in ST_LOAD;
// one at or beyond 1024 (flagged out of range, value 0) goes straight to ST_LOAD.
// An index at or past the filled count first extends the table entry by entry;
// entry m sums T(m) terms, where T(m), about 2*sqrt(2m/3), is the number of
// pentagonal offsets not above m; one term is read and accumulated each cycle
// through the single read port of the store and one 64-bit add/subtract unit.
// The result is then read as for an index in the table once the last entry is
// written. Filling the whole table up to 1023 happens once; later queries hit.
// Reset empties the filled part of the table back to the 128 seed entries; no
// clearing pass is needed. A result waits in the output register while out_o is
// stalled; the next query may be accepted meanwhile and is held before its own
// result stage until the register frees.
`include "assert_macros.svh"

module partition_number_table_mod_2_64_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  pntm_in_if.sink    in_i,
  pntm_out_if.source out_o
);
  import pntm_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILL  = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_LOOK  = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  filled_q, filled_d;
  logic [IDX_W-1:0]  n_q, n_d;
  logic              oor_q, oor_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [ADDR_W-1:0] k_q, k_d;
  logic              phase_q, phase_d;
  logic              neg_q, neg_d;
  logic              term_vld_q, term_vld_d;
  logic              term_neg_q, term_neg_d;
  logic [VAL_W-1:0]  acc_q, acc_d;
  logic              out_vld_q, out_vld_d;
  logic [VAL_W-1:0]  out_val_q, out_val_d;
  logic              out_oor_q, out_oor_d;

  logic [ADDR_W-1:0] rd_addr;
  logic [VAL_W-1:0]  rd_data;
  pntm_wr_t          wr;
  logic              in_acc;
  logic              out_free;

  pntm_store u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_data_o (rd_data)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;

  assign rd_addr = (state_q == ST_FILL) ? ADDR_W'(OFF_W'(filled_q) - off_q)
                                        : n_q[ADDR_W-1:0];

  always_comb begin
    state_d    = state_q;
    filled_d   = filled_q;
    n_d        = n_q;
    oor_d      = oor_q;
    off_d      = off_q;
    k_d        = k_q;
    phase_d    = phase_q;
    neg_d      = neg_q;
    term_vld_d = 1'b0;
    term_neg_d = term_neg_q;
    acc_d      = acc_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_val_d  = out_val_q;
    out_oor_d  = out_oor_q;
    wr.en      = 1'b0;
    wr.addr    = filled_q[ADDR_W-1:0];
    wr.data    = acc_q;

    // accumulate the term read in the previous cycle
    if (term_vld_q) begin
      acc_d = term_neg_q ? (acc_q - rd_data) : (acc_q + rd_data);
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          n_d = in_i.index;
          if (in_i.index >= TABLE_ENTRIES) begin
            oor_d   = 1'b1;
            state_d = ST_LOAD;
          end else if (in_i.index < filled_q) begin
            oor_d   = 1'b0;
            state_d = ST_LOOK;
          end else begin
            oor_d   = 1'b0;
            off_d   = OFF_W'(1);
            k_d     = ADDR_W'(1);
            phase_d = 1'b0;
            neg_d   = 1'b0;
            acc_d   = '0;
            state_d = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        if (off_q <= OFF_W'(filled_q)) begin
          term_vld_d = 1'b1;
          term_neg_d = neg_q;
          if (!phase_q) begin
            off_d   = off_q + OFF_W'(k_q);
            phase_d = 1'b1;
          end else begin
            off_d   = off_q + OFF_W'({k_q, 1'b1});
            k_d     = k_q + ADDR_W'(1);
            neg_d   = !neg_q;
            phase_d = 1'b0;
          end
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        wr.en    = 1'b1;
        filled_d = filled_q + CNT_W'(1);
        if (filled_q < n_q) begin
          off_d   = OFF_W'(1);
          k_d     = ADDR_W'(1);
          phase_d = 1'b0;
          neg_d   = 1'b0;
          acc_d   = '0;
          state_d = ST_FILL;
        end else begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_val_d = oor_q ? '0 : rd_data;
          out_oor_d = oor_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      filled_q   <= CNT_W'(SEED_ENTRIES);
      term_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      filled_q   <= filled_d;
      term_vld_q <= term_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    oor_q      <= oor_d;
    off_q      <= off_d;
    k_q        <= k_d;
    phase_q    <= phase_d;
    neg_q      <= neg_d;
    term_neg_q <= term_neg_d;
    acc_q      <= acc_d;
    out_val_q  <= out_val_d;
    out_oor_q  <= out_oor_d;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.value        = out_val_q;
  assign out_o.out_of_range = out_oor_q;

  `PNTM_ASSERT(a_filled_range,
    filled_q >= CNT_W'(SEED_ENTRIES) && filled_q <= CNT_W'(TABLE_ENTRIES),
    "filled count left its range")
  `PNTM_ASSERT(a_fill_bounded, state_q == ST_FILL |-> filled_q <= n_q,
    "table extended beyond the queried index")
  `PNTM_ASSERT(a_write_step, state_q == ST_WRITE |=> filled_q == $past(filled_q) + CNT_W'(1),
    "filled count did not advance after an entry write")
  `PNTM_ASSERT(a_oor_zero, out_o.valid && out_o.out_of_range |-> out_o.value == '0,
    "out of range item carries a nonzero value")
  `PNTM_ASSERT(a_no_term_outside_fill,
    term_vld_q |-> state_q == ST_FILL || state_q == ST_WRITE,
    "term accumulated outside a table fill")

endmodule

// ----- rtl/pntm_store.sv -----
// Partition table store: seed ROM and entry memory behind one registered read port.
module pntm_store (
  input  logic                     clk_i,
  input  logic [pntm_pkg::ADDR_W-1:0] rd_addr_i,
  input  pntm_pkg::pntm_wr_t       wr_i,
  output logic [pntm_pkg::VAL_W-1:0]  rd_data_o
);
  import pntm_pkg::*;

  logic [VAL_W-1:0] mem [TABLE_ENTRIES];
  logic [VAL_W-1:0] mem_q;
  logic [VAL_W-1:0] rom_q;
  logic             sel_rom_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    mem_q     <= mem[rd_addr_i];
    rom_q     <= SEED_ROM[rd_addr_i[ROM_W-1:0]];
    sel_rom_q <= (rd_addr_i < SEED_ENTRIES);
  end

  assign rd_data_o = sel_rom_q ? rom_q : mem_q;

endmodule
